/* rtl/upd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg
// Shared constants, types and digit helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_F   = 8'h66;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_F    = 8'h46;
	localparam logic [7:0] HEX_TEN    = 8'd10;

	localparam int QueueDepth = 4;

	typedef enum logic [2:0] {
		PH_PLAIN = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	// One queued command: one or two output bytes for one input beat.
	typedef struct packed {
		logic       two;
		logic [7:0] b0;
		logic [7:0] b1;
		logic       last;
	} cmd_t;

	// {valid, value} for a first digit: 0-9, a-f.
	function automatic logic [4:0] first_val(input logic [7:0] b);
		logic [7:0] d;
		d = 8'h00;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			d = b - CH_ZERO;
			return {1'b1, d[3:0]};
		end else if (b >= CH_LOW_A && b <= CH_LOW_F) begin
			d = b - CH_LOW_A + HEX_TEN;
			return {1'b1, d[3:0]};
		end
		return 5'b0_0000;
	endfunction

	// {valid, value} for a second digit: 0-9, a-f, A-F.
	function automatic logic [4:0] second_val(input logic [7:0] b);
		logic [4:0] f;
		logic [7:0] d;
		f = first_val(b);
		d = 8'h00;
		if (f[4]) begin
			return f;
		end else if (b >= CH_UP_A && b <= CH_UP_F) begin
			d = b - CH_UP_A + HEX_TEN;
			return {1'b1, d[3:0]};
		end
		return 5'b0_0000;
	endfunction

endpackage

/* rtl/url_percent_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_top
// URL percent decoder: raw bytes in, decoded bytes out.
// ----------------------------------------------------------------------------
// Slave channel s_*: one encoded byte per beat, s_tlast on the final byte of
// a string. Master channel m_*: one decoded byte per beat, m_tlast on the
// final beat of the string, m_tuser high on the last beat caused by an input.
// The front half classifies each byte ('+' to space, '%' escapes) and queues
// a command of one or two bytes; the back half drains the queue through a
// registered output stage. Bytes that only advance an escape make no beat.
// An input beat passes through the command queue, then the output register.
// Throughput is one input beat per cycle while the queue has room; a command
// with two bytes holds the back half for both bytes; the queue absorbs it.
// When m_tready is low, output holds and the queue fills; s_tready drops
// only when the queue of QUEUE_DEPTH commands is full.
// Reset clears the escape state, empties the queue and drops m_tvalid.
// ----------------------------------------------------------------------------
module url_percent_decoder_top import upd_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // string_end
	output logic       m_tuser    // [0] run_end
);

	cmd_t cmd, head;
	logic push, pop, full, empty;

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (full),
		.in_ready (s_tready),
		.push     (push),
		.cmd      (cmd)
	);

	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (cmd),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	upd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

/* rtl/upd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_front
// Accepts raw bytes, tracks the escape phase and issues output commands.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       q_full,
	output logic       in_ready,
	output logic       push,
	output cmd_t       cmd
);

	phase_t     phase_q, phase_d;
	logic [3:0] digit_q, digit_d;
	logic [7:0] b;
	logic [4:0] fv, sv;
	logic       emit;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && emit;

	always_comb begin
		b       = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
		fv      = first_val(b);
		sv      = second_val(b);
		phase_d = phase_q;
		digit_d = digit_q;
		emit    = 1'b0;
		cmd     = '{two: 1'b0, b0: b, b1: b, last: in_last};
		unique case (phase_q)
			PH_PCT: begin
				if (fv[4]) begin
					if (in_last) begin
						emit   = 1'b1;
						cmd.b0 = {4'h0, fv[3:0]};
					end else begin
						digit_d = fv[3:0];
						phase_d = PH_DIGIT;
					end
				end else begin
					emit   = 1'b1;
					cmd.b0 = CH_PERCENT;
					if (b == CH_PERCENT && !in_last) begin
						phase_d = PH_PCT;
					end else begin
						cmd.two = 1'b1;
						phase_d = PH_PLAIN;
					end
				end
			end
			PH_DIGIT: begin
				emit    = 1'b1;
				cmd.b0  = sv[4] ? {digit_q, sv[3:0]} : {4'h0, digit_q};
				phase_d = PH_PLAIN;
			end
			default: begin
				if (b == CH_PERCENT && !in_last) begin
					phase_d = PH_PCT;
				end else begin
					emit    = 1'b1;
					phase_d = PH_PLAIN;
				end
			end
		endcase
		if (in_last) begin
			phase_d = PH_PLAIN;
			digit_d = 4'h0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			digit_q <= 4'h0;
		end else if (accept) begin
			phase_q <= phase_d;
			digit_q <= digit_d;
		end
	end

endmodule

/* rtl/upd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_queue
// Small command FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module upd_queue import upd_pkg::*; #(
	parameter int DEPTH = QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/upd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_back
// Drains commands into output beats through a registered output stage.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       empty,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic       m_tuser
);

	logic       valid_q;
	logic       second_q;
	logic [7:0] data_q;
	logic       run_end_q;
	logic       str_end_q;
	logic       load;
	logic       first_of_two;

	assign load         = !valid_q || m_tready;
	assign first_of_two = head.two && !second_q;
	assign pop          = load && !empty && !first_of_two;

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = str_end_q;
	assign m_tuser  = run_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				second_q <= first_of_two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			data_q    <= (head.two && second_q) ? head.b1 : head.b0;
			run_end_q <= !first_of_two;
			str_end_q <= !first_of_two && head.last;
		end
	end

endmodule

/* tb/url_percent_decoder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_top_tb
// Self-checking bench for the URL percent decoder. Strings are streamed in
// one byte per beat. A scoreboard class keeps its own copy of the escape
// state and predicts every decoded beat. Each output beat is checked
// against the oldest prediction.
// Stimulus is a directed set of escape corner cases, then random strings,
// mostly well-formed escapes mixed with noise. The random part runs under
// several idle and stall mixes, with one long output hold-off.
// ----------------------------------------------------------------------------
module url_percent_decoder_top_tb import upd_pkg::*;;

	localparam int HalfPeriod   = 2;
	localparam int RandomItems  = 850;
	localparam int IdleLimit    = 2000;
	localparam int HoldCycles   = 300;
	localparam int TailCycles   = 8;

	typedef struct {
		logic [7:0] data;
		logic       run_end;
		logic       string_end;
	} decoded_beat_t;

	class decoded_byte_board;
		decoded_beat_t pending_bytes[$];
		phase_t        phase;
		logic [3:0]    held_digit;
		int            mismatches;

		function new();
			phase      = PH_PLAIN;
			held_digit = 4'h0;
			mismatches = 0;
		endfunction

		task report(input string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		function int hex_value(input logic [7:0] b, input bit allow_upper);
			if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
			if (b >= CH_LOW_A && b <= CH_LOW_F) return int'(b - CH_LOW_A) + 10;
			if (allow_upper && b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A) + 10;
			return -1;
		endfunction

		function void note_raw_byte(input logic [7:0] raw, input logic last);
			logic [7:0]    b;
			logic [7:0]    outs[$];
			int            d;
			decoded_beat_t beat;
			b = (raw == CH_PLUS) ? CH_SPACE : raw;
			case (phase)
				PH_PCT: begin
					d = hex_value(b, 1'b0);
					if (d >= 0) begin
						if (last) begin
							outs.push_back(8'(d));
						end else begin
							held_digit = 4'(d);
							phase      = PH_DIGIT;
						end
					end else begin
						outs.push_back(CH_PERCENT);
						if (b == CH_PERCENT && !last) begin
							phase = PH_PCT;
						end else begin
							outs.push_back(b);
							phase = PH_PLAIN;
						end
					end
				end
				PH_DIGIT: begin
					d = hex_value(b, 1'b1);
					if (d >= 0) outs.push_back({held_digit, 4'(d)});
					else outs.push_back({4'h0, held_digit});
					phase = PH_PLAIN;
				end
				default: begin
					if (b == CH_PERCENT && !last) begin
						phase = PH_PCT;
					end else begin
						outs.push_back(b);
						phase = PH_PLAIN;
					end
				end
			endcase
			foreach (outs[i]) begin
				beat.data       = outs[i];
				beat.run_end    = (i == outs.size() - 1);
				beat.string_end = (i == outs.size() - 1) && last;
				pending_bytes.push_back(beat);
			end
			if (last) begin
				phase      = PH_PLAIN;
				held_digit = 4'h0;
			end
		endfunction

		task check_decoded_beat(input logic [7:0] data, input logic tlast, input logic tuser);
			decoded_beat_t want;
			if (pending_bytes.size() == 0) begin
				report($sformatf("unexpected beat data=%h tlast=%b tuser=%b", data, tlast, tuser));
				return;
			end
			want = pending_bytes.pop_front();
			if (data !== want.data)
				report($sformatf("data got %h want %h", data, want.data));
			if (tuser !== want.run_end)
				report($sformatf("run end got %b want %b (data %h)", tuser, want.run_end, want.data));
			if (tlast !== want.string_end)
				report($sformatf("string end got %b want %b (data %h)", tlast,
				                 want.string_end, want.data));
		endtask
	endclass

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	decoded_byte_board board = new();

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_seq      = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int idle_cycles   = 0;
	int sent_items    = 0;

	string hex_chars = "0123456789abcdefABCDEF";

	url_percent_decoder_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #(HalfPeriod) clk = ~clk;

	// output side: check beats, then drive tready
	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_decoded_beat(m_tdata, m_tlast, m_tuser);
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HoldCycles;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_raw_byte(b, last);
		sent_items++;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending_bytes.size() != 0) @(posedge clk);
	endtask

	task automatic send_random_string();
		int         len;
		int         k;
		logic [7:0] chars[$];
		len = $urandom_range(1, 10);
		while (chars.size() < len) begin
			k = $urandom_range(99);
			if (k < 40) begin
				chars.push_back(CH_PERCENT);
				chars.push_back(hex_chars[$urandom_range(15)]);
				chars.push_back(hex_chars[$urandom_range(21)]);
			end else if (k < 50) begin
				chars.push_back(CH_PERCENT);
				chars.push_back(8'($urandom_range(255)));
			end else if (k < 58) begin
				chars.push_back(CH_PERCENT);
				chars.push_back(hex_chars[$urandom_range(15)]);
				chars.push_back(8'($urandom_range(255)));
			end else if (k < 68) begin
				chars.push_back(CH_PLUS);
			end else if (k < 74) begin
				chars.push_back(CH_PERCENT);
			end else begin
				chars.push_back(8'($urandom_range(255)));
			end
		end
		// an escape may straddle the end, leaving it cut short
		while (chars.size() > len) void'(chars.pop_back());
		foreach (chars[i]) send_byte(chars[i], i == chars.size() - 1);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_string("a+b");
		send_string("%41");
		send_string("%fF");
		send_string("%G%");
		send_string("%%5");
		send_string("%az");
		send_string("%+");
		send_string("%%");
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 54;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 54;
				end
				default: begin
					send_idle_pct = 19;
					stall_pct     = 19;
				end
			endcase
			if (ph == 0) hold_seq++;
			while (sent_items < 25 + (RandomItems * (ph + 1)) / 4) send_random_string();
			wait_drained();
		end

		repeat (TailCycles) @(posedge clk);
		if (board.pending_bytes.size() != 0)
			board.report($sformatf("%0d decoded beats never arrived", board.pending_bytes.size()));
		if (board.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* url_percent_decoder_top.f */
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder_top.sv
tb/url_percent_decoder_top_tb.sv
